// ===== hw/rtl/gfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gfcd_pkg
// shared types, constants and config register codes of the grid field block
// ----------------------------------------------------------------------------
package gfcd_pkg;

	localparam int MAX_ROWS_DEF = 1024;
	localparam int MAX_COLS_DEF = 1024;

	localparam int DATA_W      = 32;
	localparam int SIZE_W      = 11;
	localparam int IDX_W       = 10;
	localparam int FRAC_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int MIN_SIZE    = 3;

	// difference, product and rounded product widths
	localparam int DIFF_W = DATA_W + 1;
	localparam int PROD_W = 2 * DATA_W + 1;
	localparam int Q_W    = PROD_W - FRAC_W;

	localparam logic [SIZE_W-1:0] ROWS_RESET = 11'd1024;
	localparam logic [SIZE_W-1:0] COLS_RESET = 11'd1024;
	localparam logic [DATA_W-1:0] INV_RESET  = 32'd65536;

	localparam logic [DATA_W-1:0] SAT_POS    = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] SAT_NEG    = 32'h8000_0000;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS = 2'd0,
		CFG_COLS = 2'd1,
		CFG_INV  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] potential;
		logic                     frame_start;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] field_x;
		logic signed [DATA_W-1:0] field_y;
		logic [IDX_W-1:0]         out_row;
		logic [IDX_W-1:0]         out_col;
		logic                     run_last;
		logic                     frame_end;
	} out_t;

	// classification of one sample by the front end
	typedef struct packed {
		logic has_out;   // row above exists, at least one result
		logic use_data;  // interior row, fields come from the neighbours
		logic last_row;  // second, zero result follows
		logic col0;      // left neighbour wraps to the row end
		logic col_last;  // right neighbour wraps to the row start
	} flags_t;

	typedef struct packed {
		flags_t           flags;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} meta_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] potential;
		meta_t                    meta;
	} cmd_t;

endpackage

// ===== hw/rtl/grid_field_central_difference_top.sv =====
// a beat passes the command queue, back stages s1 to s5 and the result queue to the ports
// throughput: one sample per cycle while the result queue has room, set by the five-stage
// back pipeline and the line buffers; a last row sample gives two results, the zero one last
// reset: clears position counters, queues and pipeline valids, loads register defaults
// reset does not clear the line buffers and there is no clearing pass
// ----------------------------------------------------------------------------
// grid_field_central_difference_top
// field components from a streamed 2D potential grid by central differences
// ----------------------------------------------------------------------------
module grid_field_central_difference_top #(
	parameter  int MAX_ROWS = gfcd_pkg::MAX_ROWS_DEF,
	parameter  int MAX_COLS = gfcd_pkg::MAX_COLS_DEF,
	localparam int CW       = $clog2(MAX_COLS),
	localparam int RSW      = $clog2(MAX_ROWS + 1),
	localparam int CSW      = $clog2(MAX_COLS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample side
	input  logic                              push,
	output logic                              full,
	input  gfcd_pkg::in_t                     sample,
	// result side
	output logic                              empty,
	input  logic                              pop,
	output gfcd_pkg::out_t                    result,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gfcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gfcd_pkg::DATA_W-1:0]       cfg_data
);

	localparam int CMD_W = $bits(gfcd_pkg::cmd_t) + CW;
	localparam int OUT_W = $bits(gfcd_pkg::out_t);

	// configuration registers
	logic [gfcd_pkg::SIZE_W-1:0] rows_q;
	logic [gfcd_pkg::SIZE_W-1:0] cols_q;
	logic [gfcd_pkg::DATA_W-1:0] inv_q;
	logic [RSW-1:0]              rows_used;
	logic [CSW-1:0]              cols_used;

	// front to back queue
	logic                        fq_wr;
	logic                        fq_full;
	logic                        fq_rd;
	logic                        fq_empty;
	gfcd_pkg::cmd_t              front_cmd;
	logic [CW-1:0]               front_col;
	logic [CMD_W-1:0]            fq_rd_data;
	gfcd_pkg::cmd_t              back_cmd;
	logic [CW-1:0]               back_col;

	// back to result queue
	logic                        oq_wr;
	logic                        oq_full;
	gfcd_pkg::out_t              back_item;
	logic [OUT_W-1:0]            oq_rd_data;

	// registers are always writable; the user must write them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gfcd_pkg::ROWS_RESET;
			cols_q <= gfcd_pkg::COLS_RESET;
			inv_q  <= gfcd_pkg::INV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gfcd_pkg::CFG_ROWS: rows_q <= cfg_data[gfcd_pkg::SIZE_W-1:0];
				gfcd_pkg::CFG_COLS: cols_q <= cfg_data[gfcd_pkg::SIZE_W-1:0];
				gfcd_pkg::CFG_INV:  inv_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame sizes are held to three up to the buffer capacity
	always_comb begin
		priority if (rows_q < gfcd_pkg::SIZE_W'(gfcd_pkg::MIN_SIZE)) begin
			rows_used = RSW'(gfcd_pkg::MIN_SIZE);
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			rows_used = RSW'(MAX_ROWS);
		end else begin
			rows_used = RSW'(rows_q);
		end
		priority if (cols_q < gfcd_pkg::SIZE_W'(gfcd_pkg::MIN_SIZE)) begin
			cols_used = CSW'(gfcd_pkg::MIN_SIZE);
		end else if (32'(cols_q) > 32'(MAX_COLS)) begin
			cols_used = CSW'(MAX_COLS);
		end else begin
			cols_used = CSW'(cols_q);
		end
	end

	// front end: position tracking and classification of each beat
	gfcd_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample    (sample),
		.q_full    (fq_full),
		.rows_used (rows_used),
		.cols_used (cols_used),
		.q_wr      (fq_wr),
		.q_cmd     (front_cmd),
		.q_col     (front_col)
	);

	assign full = fq_full;

	// short queue lets front and back stall independently
	gfcd_queue #(
		.W     (CMD_W),
		.DEPTH (gfcd_pkg::QUEUE_DEPTH)
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fq_wr),
		.wr_data ({front_cmd, front_col}),
		.full    (fq_full),
		.rd      (fq_rd),
		.rd_data (fq_rd_data),
		.empty   (fq_empty)
	);

	assign back_cmd = gfcd_pkg::cmd_t'(fq_rd_data[CMD_W-1:CW]);
	assign back_col = fq_rd_data[CW-1:0];

	// back end: line buffers, difference, scale, round and saturate
	gfcd_back #(
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (fq_empty),
		.q_cmd        (back_cmd),
		.q_col        (back_col),
		.q_pop        (fq_rd),
		.cols_used    (cols_used),
		.inv_two_step (inv_q),
		.o_full       (oq_full),
		.o_wr         (oq_wr),
		.o_item       (back_item)
	);

	// result queue decouples the consumer from the pipeline
	gfcd_queue #(
		.W     (OUT_W),
		.DEPTH (gfcd_pkg::QUEUE_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (oq_wr),
		.wr_data (back_item),
		.full    (oq_full),
		.rd      (pop),
		.rd_data (oq_rd_data),
		.empty   (empty)
	);

	assign result = gfcd_pkg::out_t'(oq_rd_data);

endmodule

// ===== hw/rtl/gfcd_queue.sv =====
// ----------------------------------------------------------------------------
// gfcd_queue
// small first-in first-out queue with full and empty flags
// ----------------------------------------------------------------------------
module gfcd_queue #(
	parameter  int W     = 8,
	parameter  int DEPTH = gfcd_pkg::QUEUE_DEPTH,
	localparam int PW    = $clog2(DEPTH),
	localparam int CNTW  = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	logic [W-1:0]    slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/gfcd_front.sv =====
// ----------------------------------------------------------------------------
// gfcd_front
// takes samples, tracks the grid position and classifies each sample
// ----------------------------------------------------------------------------
module gfcd_front #(
	parameter  int MAX_ROWS = gfcd_pkg::MAX_ROWS_DEF,
	parameter  int MAX_COLS = gfcd_pkg::MAX_COLS_DEF,
	localparam int RW       = $clog2(MAX_ROWS),
	localparam int CW       = $clog2(MAX_COLS),
	localparam int RSW      = $clog2(MAX_ROWS + 1),
	localparam int CSW      = $clog2(MAX_COLS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gfcd_pkg::in_t       sample,
	input  logic                q_full,
	input  logic [RSW-1:0]      rows_used,
	input  logic [CSW-1:0]      cols_used,
	output logic                q_wr,
	output gfcd_pkg::cmd_t      q_cmd,
	output logic [CW-1:0]       q_col
);

	logic [RW-1:0]                   row_q;
	logic [CW-1:0]                   col_q;
	logic [RW-1:0]                   r_start;
	logic [CW-1:0]                   c_start;
	logic [RW-1:0]                   rc;
	logic [CW-1:0]                   cc;
	logic [RW-1:0]                   row_nx;
	logic                            last_row;
	logic                            col_last;
	logic [RW+gfcd_pkg::IDX_W-1:0]   row_ext;
	logic [CW+gfcd_pkg::IDX_W-1:0]   col_ext;

	assign q_wr = push && !q_full;

	always_comb begin
		r_start  = sample.frame_start ? '0 : row_q;
		c_start  = sample.frame_start ? '0 : col_q;
		// counters left beyond a smaller frame wrap to zero
		rc       = (RSW'(r_start) >= rows_used) ? '0 : r_start;
		cc       = (CSW'(c_start) >= cols_used) ? '0 : c_start;
		last_row = (RSW'(rc) == rows_used - RSW'(1));
		col_last = (CSW'(cc) + CSW'(1) == cols_used);
		row_nx   = (RSW'(rc) + RSW'(1) >= rows_used) ? '0 : rc + RW'(1);
		row_ext  = {{gfcd_pkg::IDX_W{1'b0}}, rc};
		col_ext  = {{gfcd_pkg::IDX_W{1'b0}}, cc};

		q_cmd.potential           = sample.potential;
		q_cmd.meta.flags.has_out  = (rc != '0);
		q_cmd.meta.flags.use_data = (rc > RW'(1));
		q_cmd.meta.flags.last_row = last_row;
		q_cmd.meta.flags.col0     = (cc == '0);
		q_cmd.meta.flags.col_last = col_last;
		q_cmd.meta.row            = row_ext[gfcd_pkg::IDX_W-1:0];
		q_cmd.meta.col            = col_ext[gfcd_pkg::IDX_W-1:0];
		q_col                     = cc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (q_wr) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_nx;
			end else begin
				col_q <= cc + CW'(1);
				row_q <= rc;
			end
		end
	end

endmodule

// ===== hw/rtl/gfcd_back.sv =====
// ----------------------------------------------------------------------------
// gfcd_back
// line buffers, central difference pipeline and result sequencing
// ----------------------------------------------------------------------------
module gfcd_back #(
	parameter  int MAX_COLS = gfcd_pkg::MAX_COLS_DEF,
	localparam int CW       = $clog2(MAX_COLS),
	localparam int CSW      = $clog2(MAX_COLS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  gfcd_pkg::cmd_t                q_cmd,
	input  logic [CW-1:0]                 q_col,
	output logic                          q_pop,
	input  logic [CSW-1:0]                cols_used,
	input  logic [gfcd_pkg::DATA_W-1:0]   inv_two_step,
	input  logic                          o_full,
	output logic                          o_wr,
	output gfcd_pkg::out_t                o_item
);

	localparam int DW = gfcd_pkg::DATA_W;
	localparam int FW = gfcd_pkg::DIFF_W;
	localparam int PW = gfcd_pkg::PROD_W;
	localparam int QW = gfcd_pkg::Q_W;

	// line buffers: newer row held twice for a third read port
	logic [DW-1:0] newer_a_mem [MAX_COLS];
	logic [DW-1:0] newer_b_mem [MAX_COLS];
	logic [DW-1:0] older_mem   [MAX_COLS];

	logic                  adv;
	logic                  done_s5;
	logic                  second_q;
	logic [DW-1:0]         hold_prev_q;
	logic [DW-1:0]         hold_first_q;
	logic [CW-1:0]         rgt_addr;
	logic [CW-1:0]         lft_addr;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	gfcd_pkg::cmd_t        cmd_s1;
	logic [CW-1:0]         col_s1;
	logic [DW-1:0]         ctr_s1, rgt_s1, lft_s1, abv_s1;
	gfcd_pkg::meta_t       meta_s2, meta_s3, meta_s4, meta_s5;
	logic [FW-1:0]         dx_s2, dy_s2;
	logic [FW-1:0]         magx_s3, magy_s3;
	logic                  negx_s3, negy_s3;
	logic [PW-1:0]         prodx_s4, prody_s4;
	logic                  negx_s4, negy_s4;
	logic [QW-1:0]         qx_s5, qy_s5;
	logic                  negx_s5, negy_s5;

	logic [DW-1:0]         pot_s1;
	logic [DW-1:0]         left_s1;
	logic [DW-1:0]         right_s1;
	logic [FW-1:0]         dx_s1, dy_s1;
	logic [PW-1:0]         rndx_s4, rndy_s4;
	logic [DW-1:0]         fx_s5, fy_s5;
	gfcd_pkg::out_t        res_mid, res_end;

	function automatic logic [DW-1:0] sat_sign(input logic [QW-1:0] q, input logic neg);
		logic [DW-1:0] r;
		if (neg) begin
			if (q >= QW'(gfcd_pkg::SAT_NEG)) begin
				r = gfcd_pkg::SAT_NEG;
			end else begin
				r = DW'(0) - q[DW-1:0];
			end
		end else begin
			if (q > QW'(gfcd_pkg::SAT_POS)) begin
				r = gfcd_pkg::SAT_POS;
			end else begin
				r = q[DW-1:0];
			end
		end
		return r;
	endfunction

	// whole pipeline moves together, held by the result stage
	assign done_s5 = !meta_s5.flags.has_out ||
		(!o_full && (!meta_s5.flags.last_row || second_q));
	assign adv     = !v_s5 || done_s5;
	assign q_pop   = adv && !q_empty;
	assign o_wr    = v_s5 && meta_s5.flags.has_out && !o_full;

	assign rgt_addr = q_cmd.meta.flags.col_last ? '0 : q_col + CW'(1);
	assign lft_addr = CW'(cols_used - CSW'(1));

	// s1: neighbour selection and differences
	always_comb begin
		pot_s1   = cmd_s1.potential;
		left_s1  = cmd_s1.meta.flags.col0 ? lft_s1 : hold_prev_q;
		right_s1 = cmd_s1.meta.flags.col_last ? hold_first_q : rgt_s1;
		dx_s1    = {abv_s1[DW-1], abv_s1} - {pot_s1[DW-1], pot_s1};
		dy_s1    = {left_s1[DW-1], left_s1} - {right_s1[DW-1], right_s1};
	end

	// s4: round to nearest, ties away from zero
	assign rndx_s4 = prodx_s4 + gfcd_pkg::ROUND_HALF;
	assign rndy_s4 = prody_s4 + gfcd_pkg::ROUND_HALF;

	// s5: sign and saturation, boundary rows give zero
	always_comb begin
		fx_s5 = meta_s5.flags.use_data ? sat_sign(qx_s5, negx_s5) : '0;
		fy_s5 = meta_s5.flags.use_data ? sat_sign(qy_s5, negy_s5) : '0;

		res_mid.field_x   = fx_s5;
		res_mid.field_y   = fy_s5;
		res_mid.out_row   = meta_s5.row - gfcd_pkg::IDX_W'(1);
		res_mid.out_col   = meta_s5.col;
		res_mid.run_last  = !meta_s5.flags.last_row;
		res_mid.frame_end = 1'b0;

		res_end.field_x   = '0;
		res_end.field_y   = '0;
		res_end.out_row   = meta_s5.row;
		res_end.out_col   = meta_s5.col;
		res_end.run_last  = 1'b1;
		res_end.frame_end = meta_s5.flags.col_last;

		o_item = second_q ? res_end : res_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			second_q     <= 1'b0;
			hold_prev_q  <= '0;
			hold_first_q <= '0;
		end else begin
			if (adv) begin
				v_s1     <= !q_empty;
				v_s2     <= v_s1;
				v_s3     <= v_s2;
				v_s4     <= v_s3;
				v_s5     <= v_s4;
				second_q <= 1'b0;
			end else if (o_wr) begin
				second_q <= 1'b1;
			end
			if (adv && v_s1) begin
				hold_prev_q <= ctr_s1;
				if (cmd_s1.meta.flags.col0) begin
					hold_first_q <= ctr_s1;
				end
			end
		end
	end

	// line buffer writes as an item leaves s1
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			newer_a_mem[col_s1] <= pot_s1;
			newer_b_mem[col_s1] <= pot_s1;
			older_mem[col_s1]   <= ctr_s1;
		end
	end

	// stage registers, reads forward the write of the same edge
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= q_cmd;
			col_s1 <= q_col;
			ctr_s1 <= (v_s1 && q_col == col_s1) ? pot_s1 : newer_a_mem[q_col];
			rgt_s1 <= (v_s1 && rgt_addr == col_s1) ? pot_s1 : newer_a_mem[rgt_addr];
			lft_s1 <= (v_s1 && lft_addr == col_s1) ? pot_s1 : newer_b_mem[lft_addr];
			abv_s1 <= (v_s1 && q_col == col_s1) ? ctr_s1 : older_mem[q_col];

			meta_s2 <= cmd_s1.meta;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;

			meta_s3 <= meta_s2;
			negx_s3 <= dx_s2[FW-1];
			negy_s3 <= dy_s2[FW-1];
			magx_s3 <= dx_s2[FW-1] ? FW'(0) - dx_s2 : dx_s2;
			magy_s3 <= dy_s2[FW-1] ? FW'(0) - dy_s2 : dy_s2;

			meta_s4  <= meta_s3;
			negx_s4  <= negx_s3;
			negy_s4  <= negy_s3;
			prodx_s4 <= PW'(magx_s3) * PW'(inv_two_step);
			prody_s4 <= PW'(magy_s3) * PW'(inv_two_step);

			meta_s5 <= meta_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			qx_s5   <= rndx_s4[PW-1:gfcd_pkg::FRAC_W];
			qy_s5   <= rndy_s4[PW-1:gfcd_pkg::FRAC_W];
		end
	end

`ifndef SYNTHESIS
	a_second_only_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (v_s5 && meta_s5.flags.last_row && meta_s5.flags.has_out))
		else $error("second result pending outside the last row");

	a_last_row_two_beats: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && meta_s5.flags.last_row && !second_q && o_wr) |=> (second_q && v_s5))
		else $error("zero result of the last row not scheduled");

	a_stall_holds_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !adv) |=> (v_s5 && $stable(meta_s5) && $stable(qx_s5)))
		else $error("result stage changed while stalled");

	a_interior_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && cmd_s1.meta.flags.use_data) |-> cmd_s1.meta.flags.has_out)
		else $error("interior sample without a result");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the central difference field block: streams
// potential frames through the sample queue, predicts every result point
// with a local line buffer model and checks each popped beat against it
// ----------------------------------------------------------------------------
module testbench;
	import gfcd_pkg::*;

	// run shape
	localparam int     RANDOM_ITEMS  = 220;
	localparam int     DRAIN_CYCLES  = 12;      // pipeline latency plus margin
	localparam int     END_LIMIT     = 100000;  // cycles allowed for the last results
	localparam int     MAX_REPORTS   = 10;
	localparam longint TIMEOUT_NS    = 10_000_000;

	// idling patterns of the two queue sides
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, all driven to known values from time zero
	logic                 push      = 1'b0;
	logic                 full;
	in_t                  sample    = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	out_t                 result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
	logic [DATA_W-1:0]    cfg_data  = '0;

	// idling odds in percent, changed per phase
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned error_count    = 0;

	// result points still owed by the block, oldest first
	out_t pending_points[$];

	// local copy of the block state and registers
	logic [SIZE_W-1:0] rows_reg = ROWS_RESET;
	logic [SIZE_W-1:0] cols_reg = COLS_RESET;
	logic [DATA_W-1:0] inv_reg  = INV_RESET;
	logic [DATA_W-1:0] older_row [MAX_COLS_DEF] = '{default: '0};
	logic [DATA_W-1:0] newer_row [MAX_COLS_DEF] = '{default: '0};
	int unsigned       row_pos    = 0;
	int unsigned       col_pos    = 0;
	logic [DATA_W-1:0] prev_hold  = '0;
	logic [DATA_W-1:0] first_hold = '0;

	grid_field_central_difference_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void log_failure(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	// sizes outside the legal range are pulled to the nearest bound
	function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned limit);
		if (v < MIN_SIZE) return MIN_SIZE;
		if (v > limit) return limit;
		return v;
	endfunction

	// (a - b) * inv in q16.16: magnitude rounded half away from zero, then saturated
	function automatic logic [DATA_W-1:0] scaled_gradient(logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b, logic [DATA_W-1:0] inv);
		logic [DIFF_W-1:0] diff;
		logic [DIFF_W-1:0] mag;
		logic [63:0]       q;
		diff = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		mag  = diff[DIFF_W-1] ? (~diff + 33'd1) : diff;
		q    = ({31'd0, mag} * {32'd0, inv} + 64'h8000) >> FRAC_W;
		if (diff[DIFF_W-1]) begin
			if (q >= 64'h8000_0000) return SAT_NEG;
			return ~q[DATA_W-1:0] + 32'd1;
		end
		if (q > 64'h7fff_ffff) return SAT_POS;
		return q[DATA_W-1:0];
	endfunction

	// one accepted sample: queue the points it completes and advance the line buffers
	function automatic void predict_field_points(in_t s);
		int unsigned       nrows;
		int unsigned       ncols;
		int unsigned       r;
		int unsigned       c;
		logic [DATA_W-1:0] pot;
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;
		logic [DATA_W-1:0] above;
		logic              last_row;
		out_t              pt;
		nrows = clamp_size(rows_reg, MAX_ROWS_DEF);
		ncols = clamp_size(cols_reg, MAX_COLS_DEF);
		pot   = s.potential;
		if (s.frame_start) begin
			row_pos = 0;
			col_pos = 0;
		end
		// counters left beyond a shrunk size wrap before the sample lands
		if (row_pos >= nrows) row_pos = 0;
		if (col_pos >= ncols) col_pos = 0;
		r        = row_pos;
		c        = col_pos;
		last_row = (r == nrows - 1);
		left     = (c == 0) ? newer_row[ncols-1] : prev_hold;
		if (c + 1 == ncols) begin
			right = first_hold;
		end else begin
			right = newer_row[c+1];
		end
		above = older_row[c];
		if (r >= 1) begin
			pt = '0;
			if (r >= 2) begin
				pt.field_x = scaled_gradient(above, pot, inv_reg);
				pt.field_y = scaled_gradient(left, right, inv_reg);
			end
			pt.out_row  = IDX_W'(r - 1);
			pt.out_col  = IDX_W'(c);
			pt.run_last = !last_row;
			pending_points.push_back(pt);
			// last row points have zero field and trail the interior point
			if (last_row) begin
				pt           = '0;
				pt.out_row   = IDX_W'(r);
				pt.out_col   = IDX_W'(c);
				pt.run_last  = 1'b1;
				pt.frame_end = (c + 1 == ncols);
				pending_points.push_back(pt);
			end
		end
		prev_hold = newer_row[c];
		if (c == 0) first_hold = newer_row[0];
		older_row[c] = newer_row[c];
		newer_row[c] = pot;
		col_pos = c + 1;
		if (col_pos >= ncols) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= nrows) row_pos = 0;
		end
	endfunction

	// result side: check each popped beat, then pick the next pop at random
	always @(posedge clk) begin
		out_t want;
		if (arst_n && pop && !empty) begin
			if (pending_points.size() == 0) begin
				log_failure($sformatf("unexpected result row=%0d col=%0d",
					result.out_row, result.out_col));
			end else begin
				want = pending_points.pop_front();
				if (result.field_x !== want.field_x || result.field_y !== want.field_y ||
						result.out_row !== want.out_row || result.out_col !== want.out_col ||
						result.run_last !== want.run_last ||
						result.frame_end !== want.frame_end) begin
					log_failure($sformatf(
						"exp %h %h r%0d c%0d l%b e%b, got %h %h r%0d c%0d l%b e%b",
						want.field_x, want.field_y, want.out_row, want.out_col,
						want.run_last, want.frame_end,
						result.field_x, result.field_y, result.out_row, result.out_col,
						result.run_last, result.frame_end));
				end
			end
		end
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 49;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 49;
			end
			default: begin
				send_idle_pct  = 19;
				recv_stall_pct = 19;
			end
		endcase
	endtask

	// send one sample beat, with a random gap first, and predict it once taken
	task automatic push_sample(logic [DATA_W-1:0] pot, logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push               <= 1'b1;
		sample.potential   <= pot;
		sample.frame_start <= start;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_field_points('{potential: pot, frame_start: start});
	endtask

	// hold the sample side until every owed point is out and the pipeline is empty
	task automatic wait_results_drained();
		push <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register beat; valid stays high so writes can follow back to back
	task automatic write_register(cfg_idx_t idx, logic [DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_ROWS: rows_reg = value[SIZE_W-1:0];
			CFG_COLS: cols_reg = value[SIZE_W-1:0];
			default:  inv_reg  = value;
		endcase
	endtask

	// full reprogram while idle; unused upper bits of the size words carry noise
	task automatic configure_grid(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols,
			logic [DATA_W-1:0] inv);
		wait_results_drained();
		write_register(CFG_ROWS, {21'($urandom()), rows});
		write_register(CFG_COLS, {21'($urandom()), cols});
		write_register(CFG_INV, inv);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] corner_value(int unsigned k);
		case (k)
			0: return SAT_POS;
			1: return SAT_NEG;
			2: return '0;
			3: return 32'd1;
			4: return 32'hffff_ffff;
			5: return SAT_POS;
			6: return SAT_NEG;
			7: return SAT_POS;
			default: return 32'h0001_0000;
		endcase
	endfunction

	// mostly full range noise, with small values and extremes mixed in
	function automatic logic [DATA_W-1:0] random_potential();
		logic [DATA_W-1:0] small_val;
		small_val = $urandom_range(0, 32'h0003_ffff);
		case ($urandom_range(9))
			0: return corner_value($urandom_range(4));
			1, 2, 3: return $urandom_range(1) ? small_val : -small_val;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] random_scale();
		case ($urandom_range(5))
			0: return INV_RESET;
			1: return '0;
			2: return 32'hffff_ffff;
			3: return $urandom_range(1, 32'h0002_0000);
			default: return $urandom();
		endcase
	endfunction

	// smallest grid with extreme samples: full scale, saturating scale, restart mid row
	task automatic test_directed_corners();
		set_idling(IDLE_NONE);
		configure_grid(11'd3, 11'd3, INV_RESET);
		for (int k = 0; k < 9; k++) push_sample(corner_value(k), k == 0);
		// sizes below the minimum clamp to three, largest scale saturates both ways
		configure_grid(11'd0, 11'd2, 32'hffff_ffff);
		for (int k = 0; k < 9; k++) push_sample(corner_value(8 - k), k == 0);
		// a new frame marked in the middle of row one restarts the counters
		configure_grid(11'd3, 11'd3, 32'd1);
		for (int k = 0; k < 10; k++) push_sample(corner_value(k % 9), k == 0 || k == 4);
	endtask

	// shrinking the grid mid frame leaves counters beyond the new size, which wrap
	task automatic test_mid_frame_resize();
		set_idling(IDLE_BOTH);
		configure_grid(11'd8, 11'd12, random_scale());
		for (int k = 0; k < 12 * 5 + 7; k++) push_sample(random_potential(), k == 0);
		wait_results_drained();
		write_register(CFG_COLS, 32'd5);
		cfg_valid <= 1'b0;
		for (int k = 0; k < 7; k++) push_sample(random_potential(), 1'b0);
		wait_results_drained();
		write_register(CFG_ROWS, 32'd4);
		cfg_valid <= 1'b0;
		for (int k = 0; k < 24; k++) push_sample(random_potential(), 1'b0);
	endtask

	// random small grids, whole frames with random content, some cut short
	task automatic test_random_frames();
		int unsigned       sent;
		int unsigned       phase;
		int unsigned       frames;
		int unsigned       nr;
		int unsigned       nc;
		int unsigned       cut;
		logic [SIZE_W-1:0] rows_cfg;
		logic [SIZE_W-1:0] cols_cfg;
		bit                restart;
		bit                paused;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			rows_cfg = ($urandom_range(4) == 0) ? 11'($urandom_range(0, 2)) :
				11'($urandom_range(3, 12));
			cols_cfg = ($urandom_range(4) == 0) ? 11'($urandom_range(3, 40)) :
				11'($urandom_range(0, 14));
			configure_grid(rows_cfg, cols_cfg, random_scale());
			nr      = clamp_size(rows_cfg, MAX_ROWS_DEF);
			nc      = clamp_size(cols_cfg, MAX_COLS_DEF);
			frames  = $urandom_range(1, 3);
			restart = 1'b1;
			// the first phase always holds off once until every point is back
			paused  = (phase != 0) && ($urandom_range(2) != 0);
			for (int f = 0; f < frames && sent < RANDOM_ITEMS; f++) begin
				cut = ($urandom_range(5) == 0) ? $urandom_range(1, nr * nc - 1) : nr * nc;
				for (int k = 0; k < cut; k++) begin
					if (!paused && k == cut / 2) begin
						wait_results_drained();
						paused = 1'b1;
					end
					// idling pattern steps through all four kinds every few beats
					set_idling(idle_mode_t'((sent / 16) % 4));
					// a frame that follows a whole one may simply wrap on
					push_sample(random_potential(), k == 0 && (restart || $urandom_range(1)));
					sent++;
				end
				restart = (cut != nr * nc);
			end
			phase++;
		end
	endtask

	// largest sizes: oversized settings clamp to the buffer capacity; one whole
	// widest row, then the start of the next one wrapping back to column zero
	task automatic test_largest_grid();
		set_idling(IDLE_BOTH);
		configure_grid(11'h7ff, 11'h7ff, random_scale());
		for (int k = 0; k < MAX_COLS_DEF + 6; k++) push_sample(random_potential(), k == 0);
	endtask

	initial begin
		int unsigned guard;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_mid_frame_resize();
		test_random_frames();
		test_largest_grid();
		// let the last points out, with a bound in case the block stops
		push  <= 1'b0;
		guard = 0;
		while (pending_points.size() != 0 && guard < END_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_points.size() != 0) begin
			log_failure($sformatf("%0d result points never came", pending_points.size()));
		end
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/gfcd_pkg.sv
hw/rtl/gfcd_queue.sv
hw/rtl/gfcd_front.sv
hw/rtl/gfcd_back.sv
hw/rtl/grid_field_central_difference_top.sv
tb/sv/testbench.sv
